FILE: rtl/core/nfbpa_pkg.sv
// shared types, constants and codes of the next-fit block pool allocator
package nfbpa_pkg;

	localparam int MAX_BLOCKS_DEF = 256;

	// occupancy map is organized in rows of WORD_W blocks
	localparam int WORD_W = 16;
	localparam int BIT_W  = $clog2(WORD_W);

	localparam int ADDR_W   = 32;
	localparam int BBYTES_W = 17;
	localparam int BCOUNT_W = 9;
	localparam int BBYTES_MAX = 65536;

	localparam int DIV_STEPS = ADDR_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_FULL         = 3'd1,
		ST_NOT_MULTIPLE = 3'd2,
		ST_UNSUPPORTED  = 3'd3,
		ST_BAD_FREE     = 3'd4
	} status_t;

	// classified request handed from front to back
	typedef struct packed {
		logic              is_free;
		logic              rem_zero;
		logic [ADDR_W-1:0] quot;
	} cmd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_EVAL,
		B_SCAN_RD,
		B_SCAN_CHK,
		B_MUL,
		B_FREE_RD,
		B_FREE_CHK,
		B_DONE
	} back_state_t;

endpackage

FILE: rtl/core/nfbpa_front.sv
// front end: takes requests, divides size or offset by block size, queues the command
module nfbpa_front
	import nfbpa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2*ADDR_W-1:0] s_tdata,
	input  logic                s_tuser,
	input  logic [ADDR_W-1:0]   pool_base,
	input  logic [BBYTES_W-1:0] bb,
	input  logic                q_full,
	output logic                q_push,
	output cmd_t                q_cmd
);

	front_state_t state_q, state_d;

	logic                 action_q;
	logic [ADDR_W-1:0]    dividend_q;
	logic [BBYTES_W-2:0]  rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [BBYTES_W-1:0] trial;
	logic                ge;
	logic                accept;

	assign trial  = {rem_q, dividend_q[ADDR_W-1]};
	assign ge     = trial >= bb;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		q_push   = 1'b0;
		case (state_q)
			F_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = F_DIV;
			end
			F_DIV: begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = F_PUSH;
			end
			F_PUSH: begin
				q_push = !q_full;
				if (!q_full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q   <= s_tuser;
			// free: offset from pool base, allocate: byte count
			dividend_q <= s_tuser ? (s_tdata[2*ADDR_W-1:ADDR_W] - pool_base)
			                      : s_tdata[ADDR_W-1:0];
			rem_q      <= '0;
			cnt_q      <= '0;
		end else if (state_q == F_DIV) begin
			dividend_q <= {dividend_q[ADDR_W-2:0], ge};
			rem_q      <= ge ? (BBYTES_W-1)'(trial - bb) : trial[BBYTES_W-2:0];
			cnt_q      <= cnt_q + 1'b1;
		end
	end

	assign q_cmd.is_free  = action_q;
	assign q_cmd.rem_zero = (rem_q == '0);
	assign q_cmd.quot     = dividend_q;

endmodule

FILE: rtl/core/nfbpa_queue.sv
// short command queue between front and back
module nfbpa_queue
	import nfbpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t pop_cmd
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

FILE: rtl/core/nfbpa_back.sv
// back end: size checks, next-fit map scan, free, and the result register
module nfbpa_back
	import nfbpa_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	input  cmd_t                                 q_cmd,
	output logic                                 q_pop,
	input  logic [ADDR_W-1:0]                    pool_base,
	input  logic [BBYTES_W-1:0]                  bb,
	input  logic [$clog2(MAX_BLOCKS+1)-1:0]      n,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output status_t                              out_status,
	output logic [ADDR_W-1:0]                    out_address,
	output logic [$clog2(MAX_BLOCKS+1)-1:0]      out_count
);

	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int ROWS  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W = ROW_W + BIT_W;

	back_state_t state_q, state_d;

	logic [WORD_W-1:0] map_mem [ROWS];
	logic [ROWS-1:0]   row_valid_q;
	logic [WORD_W-1:0] rdata_q;

	cmd_t              cmd_q;
	logic [CNT_W-1:0]  used_q;
	logic [IDX_W-1:0]  scan_start_q;
	logic [IDX_W-1:0]  start_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ROW_W-1:0]  row_q;
	logic              pass2_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              out_valid_q;

	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] cand;
	logic              found;
	logic [BIT_W-1:0]  pick;
	logic [IDX_W-1:0]  bit_idx;
	logic [CNT_W-1:0]  n_m1;
	logic [ROW_W-1:0]  last_row;
	logic [ROW_W-1:0]  start_row;
	logic [BIT_W-1:0]  free_bit;
	logic              over_full;
	logic              quot_ge_n;
	logic [IDX_W-1:0]  first_idx;
	logic              out_free;

	assign word      = row_valid_q[row_q] ? rdata_q : '0;
	assign n_m1      = n - 1'b1;
	assign last_row  = ROW_W'(n_m1 >> BIT_W);
	assign start_row = start_q[IDX_W-1:BIT_W];
	assign free_bit  = cmd_q.quot[BIT_W-1:0];
	assign over_full = ({1'b0, cmd_q.quot} + (ADDR_W+1)'(used_q)) > (ADDR_W+1)'(n);
	assign quot_ge_n = cmd_q.quot >= ADDR_W'(n);
	assign first_idx = (ADDR_W'(scan_start_q) < ADDR_W'(n)) ? scan_start_q : '0;
	assign out_free  = !out_valid_q || m_tready;

	// free blocks of the current row that lie in the part of the cyclic order being searched
	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			bit_idx = {row_q, BIT_W'(j)};
			cand[j] = !word[j] && (ADDR_W'(bit_idx) < ADDR_W'(n))
			          && (pass2_q ? (bit_idx < start_q) : (bit_idx >= start_q));
		end
		found = 1'b0;
		pick  = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (cand[j]) begin
				found = 1'b1;
				pick  = BIT_W'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			B_IDLE: begin
				q_pop = q_valid;
				if (q_valid) state_d = B_EVAL;
			end
			B_EVAL: begin
				if (cmd_q.is_free) begin
					state_d = quot_ge_n ? B_DONE : B_FREE_RD;
				end else if (!cmd_q.rem_zero || over_full || cmd_q.quot != ADDR_W'(1)) begin
					state_d = B_DONE;
				end else begin
					state_d = B_SCAN_RD;
				end
			end
			B_SCAN_RD:  state_d = B_SCAN_CHK;
			B_SCAN_CHK: begin
				if (found) state_d = B_MUL;
				else if (pass2_q && row_q == start_row) state_d = B_DONE;
				else state_d = B_SCAN_RD;
			end
			B_MUL:      state_d = B_DONE;
			B_FREE_RD:  state_d = B_FREE_CHK;
			B_FREE_CHK: state_d = B_DONE;
			B_DONE: begin
				if (out_free) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// control state of the map and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q  <= '0;
			used_q       <= '0;
			scan_start_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == B_SCAN_CHK && found) begin
				row_valid_q[row_q] <= 1'b1;
				used_q             <= used_q + 1'b1;
				scan_start_q       <= {row_q, pick};
			end
			if (state_q == B_FREE_CHK && word[free_bit]) begin
				row_valid_q[row_q] <= 1'b1;
				used_q             <= used_q - 1'b1;
			end
			if (state_q == B_DONE && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// map row memory, one read and one write port
	always_ff @(posedge clk) begin
		if (state_q == B_SCAN_RD || state_q == B_FREE_RD) rdata_q <= map_mem[row_q];
		if (state_q == B_SCAN_CHK && found) begin
			map_mem[row_q] <= word | (WORD_W'(1) << pick);
		end
		if (state_q == B_FREE_CHK && word[free_bit]) begin
			map_mem[row_q] <= word & ~(WORD_W'(1) << free_bit);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_valid) cmd_q <= q_cmd;
			end
			B_EVAL: begin
				res_addr_q <= '0;
				if (cmd_q.is_free) begin
					res_status_q <= ST_BAD_FREE;
					row_q        <= cmd_q.quot[IDX_W-1:BIT_W];
				end else if (!cmd_q.rem_zero) begin
					res_status_q <= ST_NOT_MULTIPLE;
				end else if (over_full) begin
					res_status_q <= ST_FULL;
				end else begin
					// a count other than one; the scan overwrites it
					res_status_q <= ST_UNSUPPORTED;
					start_q      <= first_idx;
					row_q        <= first_idx[IDX_W-1:BIT_W];
					pass2_q      <= 1'b0;
				end
			end
			B_SCAN_CHK: begin
				if (found) begin
					idx_q        <= {row_q, pick};
					res_status_q <= ST_OK;
				end else if (!pass2_q && row_q == last_row) begin
					// wrap to block zero for the part below the start
					pass2_q <= 1'b1;
					row_q   <= '0;
				end else if (pass2_q && row_q == start_row) begin
					res_status_q <= ST_FULL;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
			B_MUL: begin
				res_addr_q <= pool_base + ADDR_W'(ADDR_W'(idx_q) * ADDR_W'(bb));
			end
			B_FREE_CHK: begin
				res_status_q <= word[free_bit] ? ST_OK : ST_BAD_FREE;
			end
			B_DONE: begin
				if (out_free) begin
					out_status  <= res_status_q;
					out_address <= res_addr_q;
					out_count   <= used_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

FILE: rtl/core/next_fit_block_pool_allocator.sv
// top level of the next-fit block pool allocator: registers, front, queue and back
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tdata: request_bytes, free_address; tuser: action
// m_*       out  m_tvalid/m_tready    tdata: block_address, occupied_count; tuser: status
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// the front takes a request, runs 32 divide steps and writes the queue before taking the next
// the back evaluates a rejected request or an out-of-range free and goes to the result; other
// frees add a map row read and check, and a grant a read and check per map row visited and
// an address multiply, at most ROWS+1 rows of 16 blocks
// front and back overlap through a two-entry queue; a held result stalls the back, and
// the front only once the queue is full
// reset clears the row valid bits of the map at once, so no clearing pass is needed
module next_fit_block_pool_allocator
	import nfbpa_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// request_bytes [31:0], free_address [63:32]
	input  logic [2*ADDR_W-1:0]  s_tdata,
	// action
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// block_address [31:0], occupied_count above it, zero fill
	output logic [((ADDR_W+$clog2(MAX_BLOCKS+1)+7)/8)*8-1:0] m_tdata,
	// status
	output logic [2:0]           m_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
	localparam int OUT_W   = ((ADDR_W + CNT_W + 7) / 8) * 8;

	logic [ADDR_W-1:0]   pool_base_q;
	logic [BBYTES_W-1:0] block_bytes_q;
	logic [BCOUNT_W-1:0] block_count_q;

	logic [BBYTES_W-1:0] bb;
	logic [CNT_W-1:0]    n;

	logic    q_push, q_full, q_pop, q_valid;
	cmd_t    push_cmd, pop_cmd;
	status_t out_status;
	logic [ADDR_W-1:0] out_address;
	logic [CNT_W-1:0]  out_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= '0;
			block_bytes_q <= BBYTES_W'(64);
			block_count_q <= BCOUNT_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_POOL_BASE:   pool_base_q   <= cfg_data;
				CFG_BLOCK_BYTES: block_bytes_q <= cfg_data[BBYTES_W-1:0];
				CFG_BLOCK_COUNT: block_count_q <= cfg_data[BCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// out-of-range register values are clamped into the usable range
	always_comb begin
		if (block_bytes_q == '0) bb = BBYTES_W'(1);
		else if (32'(block_bytes_q) > BBYTES_MAX) bb = BBYTES_W'(BBYTES_MAX);
		else bb = block_bytes_q;

		if (block_count_q == '0) n = CNT_W'(1);
		else if (32'(block_count_q) > MAX_BLOCKS) n = CNT_W'(MAX_BLOCKS);
		else n = CNT_W'(block_count_q);
	end

	nfbpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.pool_base (pool_base_q),
		.bb        (bb),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	nfbpa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_cmd  (pop_cmd)
	);

	nfbpa_back #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_cmd       (pop_cmd),
		.q_pop       (q_pop),
		.pool_base   (pool_base_q),
		.bb          (bb),
		.n           (n),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.out_status  (out_status),
		.out_address (out_address),
		.out_count   (out_count)
	);

	assign m_tdata = OUT_W'({out_count, out_address});
	assign m_tuser = out_status;

endmodule
